// ----- rtl/kse_pkg.sv -----
// ----------------------------------------------------------------------------
// kse_pkg - shared types and constants
// Payload structs, register indexes and operation codes for the estimator.
// ----------------------------------------------------------------------------
package kse_pkg;

    typedef struct packed {
        logic signed [31:0] speed_meas;
        logic signed [31:0] accel_meas;
        logic        [31:0] time_step;
    } kse_in_t;

    typedef struct packed {
        logic signed [31:0] speed_out;
        logic signed [31:0] accel_out;
        logic signed [47:0] position_out;
    } kse_out_t;

    localparam logic [1:0] REG_PROC  = 2'd0;
    localparam logic [1:0] REG_SPEED = 2'd1;
    localparam logic [1:0] REG_ACCEL = 2'd2;

    localparam logic [62:0] PROC_RST  = 63'd6554;
    localparam logic [62:0] SPEED_RST = 63'd6553600;
    localparam logic [62:0] ACCEL_RST = 63'd65536000000000000;

    localparam logic signed [63:0] S64_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
    localparam logic signed [63:0] S64_MIN = 64'sh8000_0000_0000_0000;

    // Arithmetic unit operations
    localparam logic [1:0] OP_MUL = 2'd0;
    localparam logic [1:0] OP_DIV = 2'd1;

    typedef struct packed {
        logic              start;
        logic [1:0]        op;
        logic signed [63:0] a;
        logic signed [63:0] b;
    } kse_req_t;

    typedef struct packed {
        logic              done;
        logic signed [63:0] res;
    } kse_rsp_t;

    function automatic logic signed [63:0] sat_add(input logic signed [63:0] a,
                                                   input logic signed [63:0] b);
        logic signed [64:0] s;
        s = {a[63], a} + {b[63], b};
        if (s > 65'sh0_7FFF_FFFF_FFFF_FFFF)      return S64_MAX;
        else if (s < -65'sh0_8000_0000_0000_0000) return S64_MIN;
        else return s[63:0];
    endfunction

    function automatic logic signed [63:0] sat_sub(input logic signed [63:0] a,
                                                   input logic signed [63:0] b);
        logic signed [64:0] s;
        s = {a[63], a} - {b[63], b};
        if (s > 65'sh0_7FFF_FFFF_FFFF_FFFF)      return S64_MAX;
        else if (s < -65'sh0_8000_0000_0000_0000) return S64_MIN;
        else return s[63:0];
    endfunction

    function automatic logic signed [63:0] clamp48(input logic signed [63:0] x);
        if (x > 64'sh0000_7FFF_FFFF_FFFF)      return 64'sh0000_7FFF_FFFF_FFFF;
        else if (x < -64'sh0000_8000_0000_0000) return -64'sh0000_8000_0000_0000;
        else return x;
    endfunction

endpackage

// ----- rtl/kalman_speed_accel_estimator.sv -----
// ----------------------------------------------------------------------------
// kalman_speed_accel_estimator - two-state Kalman speed/acceleration estimator
// Each beat runs 22 operations through one bit-serial unit: 18 multiplies and
// 4 divides. One beat in flight: a new beat is accepted only after the output
// register has taken the last result, which waits in the sequencer while the
// output register is full and out_stall is high.
// Reset: estimates zero, covariance diagonal (65536 on both), noise registers to defaults.
// ----------------------------------------------------------------------------
module kalman_speed_accel_estimator
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  kse_pkg::kse_in_t  in_data,
    output logic              out_valid,
    input  logic              out_stall,
    output kse_pkg::kse_out_t out_data,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [4:0]        paddr,
    input  logic [63:0]       pwdata,
    output logic [63:0]       prdata,
    output logic              pready
);
    import kse_pkg::*;

    logic [62:0] proc_reg, spd_reg, acc_reg;
    logic        busy_reg;
    logic        ov_reg;
    kse_out_t    od_reg;
    logic        go, fin, take;
    kse_req_t    req;
    kse_rsp_t    rsp;
    kse_out_t    res;
    logic        wr;
    logic [1:0]  ridx;

    assign pready = 1'b1;
    assign wr     = psel && penable && pwrite;
    assign ridx   = paddr[4:3];

    // register file, 8-byte stride
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            proc_reg <= PROC_RST;
            spd_reg  <= SPEED_RST;
            acc_reg  <= ACCEL_RST;
        end
        else if (wr && paddr[2:0] == 3'd0)
        begin
            unique case (ridx)
                REG_PROC:  proc_reg <= pwdata[62:0];
                REG_SPEED: spd_reg  <= pwdata[62:0];
                REG_ACCEL: acc_reg  <= pwdata[62:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        unique case (ridx)
            REG_PROC:  prdata = {1'b0, proc_reg};
            REG_SPEED: prdata = {1'b0, spd_reg};
            REG_ACCEL: prdata = {1'b0, acc_reg};
            default:   prdata = '0;
        endcase
    end

    // one beat at a time; the output register frees the sequencer
    assign in_stall = busy_reg;
    assign go       = in_valid && !busy_reg;
    // sequencer holds its result until the output register is free
    assign take     = fin && !(ov_reg && out_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            ov_reg   <= 1'b0;
        end
        else
        begin
            if (take)
            begin
                busy_reg <= 1'b0;
                ov_reg   <= 1'b1;
                od_reg   <= res;
            end
            else
            begin
                if (go)
                    busy_reg <= 1'b1;
                if (ov_reg && !out_stall)
                    ov_reg <= 1'b0;
            end
        end
    end

    assign out_valid = ov_reg;
    assign out_data  = od_reg;

    kse_arith u_arith
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .rsp   (rsp)
    );

    kse_seq u_seq
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .go         (go),
        .take       (take),
        .item       (in_data),
        .proc_noise (proc_reg),
        .spd_noise  (spd_reg),
        .acc_noise  (acc_reg),
        .req        (req),
        .rsp        (rsp),
        .fin        (fin),
        .result     (res)
    );

    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> in_stall)
        else $error("beat accepted while busy");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (ov_reg && out_stall) |=> (ov_reg && $stable(od_reg)))
        else $error("result lost under stall");

    a_fin_busy: assert property (@(posedge clk) disable iff (!rst_n)
        fin |-> busy_reg)
        else $error("finish without a beat");

endmodule

// ----- rtl/kse_arith.sv -----
// ----------------------------------------------------------------------------
// kse_arith - bit-serial multiply / divide unit
// Shift-add multiply and restoring divide on magnitudes, one bit per cycle.
// Product: (a*b)>>32, quotient: (a<<32)/b, both truncated and saturated.
// ----------------------------------------------------------------------------
module kse_arith
(
    input  logic              clk,
    input  logic              rst_n,
    input  kse_pkg::kse_req_t req,
    output kse_pkg::kse_rsp_t rsp
);
    import kse_pkg::*;

    logic              busy_reg;
    logic              op_reg;
    logic              neg_reg;
    logic [7:0]        cnt_reg;
    logic [63:0]       x_reg;     // multiplicand / divisor magnitude
    logic [127:0]      y_reg;     // multiplier bits / dividend bits (shifted out msb first)
    logic [127:0]      acc_reg;   // product accumulator
    logic [64:0]       rem_reg;
    logic [127:0]      q_reg;
    logic              done_reg;
    logic signed [63:0] res_reg;

    logic [63:0]  mag_a, mag_b;
    logic [64:0]  rem_sh;
    logic [127:0] acc_sh;
    logic [127:0] mag_res;
    logic [63:0]  hi_part;
    logic [63:0]  lo_part;
    logic signed [63:0] fin;
    logic         div_zero;

    always_comb
    begin
        mag_a  = req.a[63] ? 64'(-req.a) : req.a;
        mag_b  = req.b[63] ? 64'(-req.b) : req.b;
        div_zero = (req.op == OP_DIV) && (mag_b == 64'd0);
        rem_sh = {rem_reg[63:0], y_reg[127]};
        acc_sh = {acc_reg[126:0], 1'b0} + (y_reg[127] ? {64'd0, x_reg} : 128'd0);
        mag_res = (op_reg == OP_DIV[0]) ? q_reg : (acc_reg >> 32);
        hi_part = mag_res[127:64];
        lo_part = mag_res[63:0];
        if (!neg_reg)
            fin = (hi_part != 0 || lo_part[63]) ? S64_MAX : lo_part;
        else
            fin = (hi_part != 0 || lo_part[63]) ? S64_MIN : 64'(-lo_part);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            if (req.start)
            begin
                // zero divisor answers at once with a zero gain
                busy_reg <= !div_zero;
                done_reg <= div_zero;
                res_reg  <= '0;
                op_reg   <= req.op[0];
                neg_reg  <= req.a[63] ^ req.b[63];
                x_reg    <= mag_b;
                acc_reg  <= '0;
                rem_reg  <= '0;
                q_reg    <= '0;
                cnt_reg  <= '0;
                if (req.op == OP_DIV)
                    y_reg <= {32'd0, mag_a, 32'd0};
                else
                    y_reg <= {mag_a, 64'd0};
            end
            else if (busy_reg)
            begin
                done_reg <= 1'b0;
                if (op_reg == OP_DIV[0])
                begin
                    if (rem_sh >= {1'b0, x_reg})
                    begin
                        rem_reg <= rem_sh - {1'b0, x_reg};
                        q_reg   <= {q_reg[126:0], 1'b1};
                    end
                    else
                    begin
                        rem_reg <= rem_sh;
                        q_reg   <= {q_reg[126:0], 1'b0};
                    end
                end
                else
                    acc_reg <= acc_sh;
                y_reg   <= {y_reg[126:0], 1'b0};
                cnt_reg <= cnt_reg + 8'd1;
                if ((op_reg == OP_DIV[0] && cnt_reg == 8'd127) ||
                    (op_reg != OP_DIV[0] && cnt_reg == 8'd63))
                    busy_reg <= 1'b0;
            end
            else if (cnt_reg != 8'd0)
            begin
                done_reg <= 1'b1;
                res_reg  <= fin;
                cnt_reg  <= '0;
            end
            else
                done_reg <= 1'b0;
        end
    end

    assign rsp.done = done_reg;
    assign rsp.res  = res_reg;

endmodule

// ----- rtl/kse_seq.sv -----
// ----------------------------------------------------------------------------
// kse_seq - step sequencer
// Walks the filter equations one operation at a time through the shared unit.
// ----------------------------------------------------------------------------
module kse_seq
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              go,
    input  logic              take,
    input  kse_pkg::kse_in_t  item,
    input  logic [62:0]       proc_noise,
    input  logic [62:0]       spd_noise,
    input  logic [62:0]       acc_noise,
    output kse_pkg::kse_req_t req,
    input  kse_pkg::kse_rsp_t rsp,
    output logic              fin,
    output kse_pkg::kse_out_t result
);
    import kse_pkg::*;

    localparam int NSTEP = 27;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_ISSUE = 2'd1;
    localparam logic [1:0] ST_WAIT = 2'd2;
    localparam logic [1:0] ST_DONE = 2'd3;

    logic [1:0] st_reg;
    logic [4:0] step_reg;
    logic signed [63:0] se_reg, ae_reg, pos_reg;
    logic signed [63:0] c0_reg, c1_reg, c2_reg, c3_reg;
    logic signed [63:0] t0_reg, t1_reg, t2_reg, t3_reg, t4_reg, t5_reg, t6_reg;
    logic signed [63:0] k0_reg, k1_reg, inn_reg;
    logic signed [63:0] sm, am, dt, qn;
    kse_in_t item_reg;
    logic [1:0]        op;
    logic signed [63:0] oa, ob;
    logic signed [63:0] r;
    logic signed [63:0] pos_c;

    assign sm = 64'(item_reg.speed_meas);
    assign am = 64'(item_reg.accel_meas);
    assign dt = {32'd0, item_reg.time_step};
    assign qn = {1'b0, proc_noise};
    assign r  = rsp.res;

    // operand selection per step
    always_comb
    begin
        op = OP_MUL;
        oa = '0;
        ob = '0;
        case (step_reg)
            5'd0:  begin oa = ae_reg; ob = dt; end
            5'd1:  begin oa = dt; ob = c3_reg; end
            5'd2:  begin oa = dt; ob = sat_add(c1_reg, c2_reg); end
            5'd3:  begin oa = dt; ob = dt; end
            5'd4:  begin oa = t3_reg; ob = c3_reg; end
            5'd5:  begin op = OP_DIV; oa = t0_reg; ob = sat_add(t0_reg, {1'b0, spd_noise}); end
            5'd6:  begin op = OP_DIV; oa = t2_reg; ob = sat_add(t0_reg, {1'b0, spd_noise}); end
            5'd7:  begin oa = k0_reg; ob = inn_reg; end
            5'd8:  begin oa = k1_reg; ob = inn_reg; end
            5'd9:  begin oa = k0_reg; ob = t0_reg; end
            5'd10: begin oa = k0_reg; ob = t1_reg; end
            5'd11: begin oa = k1_reg; ob = t0_reg; end
            5'd12: begin oa = k1_reg; ob = t1_reg; end
            5'd13: begin op = OP_DIV; oa = t5_reg; ob = sat_add(t3_reg, {1'b0, acc_noise}); end
            5'd14: begin op = OP_DIV; oa = t3_reg; ob = sat_add(t3_reg, {1'b0, acc_noise}); end
            5'd15: begin oa = k0_reg; ob = inn_reg; end
            5'd16: begin oa = k1_reg; ob = inn_reg; end
            5'd17: begin oa = k0_reg; ob = t6_reg; end
            5'd18: begin oa = k0_reg; ob = t3_reg; end
            5'd19: begin oa = k1_reg; ob = t6_reg; end
            5'd20: begin oa = k1_reg; ob = t3_reg; end
            default: begin oa = se_reg; ob = dt; end
        endcase
    end

    assign req.start = (st_reg == ST_ISSUE);
    assign req.op    = op;
    assign req.a     = oa;
    assign req.b     = ob;

    // register usage:
    // t0 p00, t1 p01, t5 q01, t2 p10, t3 dt*dt / p11 / q11, t4 dtc3 / q00,
    // t6 ps / q10
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg   <= ST_IDLE;
            step_reg <= '0;
            se_reg   <= '0;
            ae_reg   <= '0;
            pos_reg  <= '0;
            c0_reg   <= 64'sd65536;
            c1_reg   <= '0;
            c2_reg   <= '0;
            c3_reg   <= 64'sd65536;
        end
        else
        begin
            unique case (st_reg)
                ST_IDLE:
                begin
                    if (go)
                    begin
                        item_reg <= item;
                        step_reg <= '0;
                        st_reg   <= ST_ISSUE;
                    end
                end
                ST_ISSUE: st_reg <= ST_WAIT;
                ST_WAIT:
                begin
                    if (rsp.done)
                    begin
                        case (step_reg)
                            5'd0: t6_reg <= clamp48(sat_add(se_reg, r)); // ps
                            5'd1: t4_reg <= r;
                            5'd2: t0_reg <= sat_add(c0_reg, r);
                            5'd3: t3_reg <= r;
                            5'd4:
                            begin
                                t0_reg <= sat_add(sat_add(t0_reg, r), qn);
                                t1_reg <= sat_add(c1_reg, t4_reg);
                                t2_reg <= sat_add(c2_reg, t4_reg);
                                t3_reg <= sat_add(c3_reg, qn);
                                inn_reg <= sat_sub(sm, t6_reg);
                                se_reg <= t6_reg;
                            end
                            5'd5: k0_reg <= r;
                            5'd6: k1_reg <= r;
                            5'd7: se_reg <= clamp48(sat_add(se_reg, r));
                            5'd8: ae_reg <= clamp48(sat_add(ae_reg, r));
                            5'd9: t4_reg <= sat_sub(t0_reg, r);
                            5'd10: t5_reg <= sat_sub(t1_reg, r);
                            5'd11: t6_reg <= sat_sub(t2_reg, r);
                            5'd12:
                            begin
                                t3_reg  <= sat_sub(t3_reg, r);
                                inn_reg <= sat_sub(am, ae_reg);
                            end
                            5'd13: k0_reg <= r;
                            5'd14: k1_reg <= r;
                            5'd15: se_reg <= clamp48(sat_add(se_reg, r));
                            5'd16: ae_reg <= clamp48(sat_add(ae_reg, r));
                            5'd17: c0_reg <= sat_sub(t4_reg, r);
                            5'd18: c1_reg <= sat_sub(t5_reg, r);
                            5'd19: c2_reg <= sat_sub(t6_reg, r);
                            5'd20: c3_reg <= sat_sub(t3_reg, r);
                            default: pos_reg <= sat_add(pos_reg, r);
                        endcase
                        if (step_reg == 5'(NSTEP - 6))
                            st_reg <= ST_DONE;
                        else
                        begin
                            step_reg <= step_reg + 5'd1;
                            st_reg   <= ST_ISSUE;
                        end
                    end
                end
                default:
                begin
                    // hold the result until the output register takes it
                    if (take)
                        st_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign fin = (st_reg == ST_DONE);

    always_comb
    begin
        pos_c = clamp48(pos_reg);
        result.speed_out = (se_reg > 64'sh7FFF_FFFF) ? 32'sh7FFF_FFFF :
                           (se_reg < -64'sh8000_0000) ? 32'sh8000_0000 : se_reg[31:0];
        result.accel_out = (ae_reg > 64'sh7FFF_FFFF) ? 32'sh7FFF_FFFF :
                           (ae_reg < -64'sh8000_0000) ? 32'sh8000_0000 : ae_reg[31:0];
        result.position_out = pos_c[47:0];
    end

endmodule

// ----- test/testbench.sv -----
// ----------------------------------------------------------------------------
// testbench - self-checking bench for the speed/acceleration estimator
// Drives measurement beats in bursts and checks every result beat against an
// in-bench fixed-point Kalman predictor. The noise registers are rewritten
// between phases, including the all-zero and all-ones extremes.
// ----------------------------------------------------------------------------
module testbench;

    import kse_pkg::*;

    // Write to an index past the last register; the block ignores it
    localparam logic [1:0] REG_NONE = 2'd3;
    localparam int DRAIN_CYCLES = 2500;
    localparam int IDLE_LIMIT   = 40000;     // longest hold-off plus several beats
    localparam int HOLD_CYCLES  = 9000;
    localparam int HOLD_AT      = 300;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    kse_in_t     in_data = '0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    kse_out_t    out_data;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [4:0]  paddr = '0;
    logic [63:0] pwdata = '0;
    logic [63:0] prdata;
    logic        pready;

    kalman_speed_accel_estimator i_dut (.*);

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // Estimator shadow: state, covariance and noise registers
    // ------------------------------------------------------------------------
    longint est_speed, est_accel, est_pos;
    longint cov [4];
    longint unsigned noise_proc, noise_speed, noise_accel;

    kse_in_t  meas_q [$];        // beats waiting to be sent
    kse_out_t estimate_q [$];    // predicted results not yet seen

    int  n_mismatch = 0;
    int  n_accepted = 0;
    bit  timed_out = 1'b0;

    function automatic logic [63:0] magn(input longint x);
        return (x < 0) ? (64'd0 - 64'(x)) : 64'(x);
    endfunction

    function automatic longint from_magn(input logic [127:0] m, input bit neg);
        if (!neg)
            return (m > 128'h7FFF_FFFF_FFFF_FFFF) ? S64_MAX : longint'(m[63:0]);
        if (m >= 128'h8000_0000_0000_0000)
            return S64_MIN;
        return -longint'(m[63:0]);
    endfunction

    function automatic longint sat64(input logic signed [65:0] v);
        if (v > 66'sh0_7FFF_FFFF_FFFF_FFFF) return S64_MAX;
        if (v < -66'sh0_8000_0000_0000_0000) return S64_MIN;
        return longint'(v[63:0]);
    endfunction

    function automatic longint plus(input longint a, input longint b);
        logic signed [65:0] s;
        s = a;
        s = s + b;
        return sat64(s);
    endfunction

    function automatic longint minus(input longint a, input longint b);
        logic signed [65:0] s;
        s = a;
        s = s - b;
        return sat64(s);
    endfunction

    function automatic longint clip(input longint x, input int bits);
        longint hi, lo;
        hi = (longint'(1) <<< (bits - 1)) - 1;
        lo = -hi - 1;
        return (x > hi) ? hi : ((x < lo) ? lo : x);
    endfunction

    // (a*b) >> 32, truncated toward zero
    function automatic longint fmul(input longint a, input longint b);
        logic [127:0] p;
        p = {64'd0, magn(a)} * {64'd0, magn(b)};
        return from_magn(p >> 32, (a < 0) != (b < 0));
    endfunction

    // (num << 32) / den, truncated toward zero; zero divisor yields zero gain
    function automatic longint fdiv(input longint num, input longint den);
        logic [127:0] q;
        if (den == 0) return 0;
        q = ({64'd0, magn(num)} << 32) / {64'd0, magn(den)};
        return from_magn(q, (num < 0) != (den < 0));
    endfunction

    task automatic kalman_update(input kse_in_t m, output kse_out_t r);
        longint sm, am, dt, qn, ps, pa, p00, p01, p10, p11, d1, k00, k10, inn;
        longint q00, q01, q10, q11, d2, k01, k11, inn2, dtc3;
        sm = longint'(m.speed_meas);
        am = longint'(m.accel_meas);
        dt = longint'({32'd0, m.time_step});
        qn = longint'(noise_proc);
        // predict
        ps   = clip(plus(est_speed, fmul(est_accel, dt)), 48);
        pa   = est_accel;
        dtc3 = fmul(dt, cov[3]);
        p00  = plus(plus(plus(cov[0], fmul(dt, plus(cov[1], cov[2]))),
                         fmul(fmul(dt, dt), cov[3])), qn);
        p01  = plus(cov[1], dtc3);
        p10  = plus(cov[2], dtc3);
        p11  = plus(cov[3], qn);
        // speed correction
        d1  = plus(p00, longint'(noise_speed));
        k00 = fdiv(p00, d1);
        k10 = fdiv(p10, d1);
        inn = minus(sm, ps);
        est_speed = clip(plus(ps, fmul(k00, inn)), 48);
        est_accel = clip(plus(pa, fmul(k10, inn)), 48);
        q00 = minus(p00, fmul(k00, p00));
        q01 = minus(p01, fmul(k00, p01));
        q10 = minus(p10, fmul(k10, p00));
        q11 = minus(p11, fmul(k10, p01));
        // acceleration correction
        d2   = plus(q11, longint'(noise_accel));
        k01  = fdiv(q01, d2);
        k11  = fdiv(q11, d2);
        inn2 = minus(am, est_accel);
        est_speed = clip(plus(est_speed, fmul(k01, inn2)), 48);
        est_accel = clip(plus(est_accel, fmul(k11, inn2)), 48);
        cov[0] = minus(q00, fmul(k01, q10));
        cov[1] = minus(q01, fmul(k01, q11));
        cov[2] = minus(q10, fmul(k11, q10));
        cov[3] = minus(q11, fmul(k11, q11));
        // position
        est_pos = plus(est_pos, fmul(est_speed, dt));
        r.speed_out    = 32'(clip(est_speed, 32));
        r.accel_out    = 32'(clip(est_accel, 32));
        r.position_out = 48'(clip(est_pos, 48));
    endtask

    // ------------------------------------------------------------------------
    // Sender: bursts of random length with random gaps
    // ------------------------------------------------------------------------
    int burst_left = 4;
    int gap_left   = 0;

    always @(posedge clk)
    begin
        bit free;
        free = !in_valid || !in_stall;
        if (rst_n && free)
        begin
            if (gap_left > 0 || meas_q.size() == 0)
            begin
                in_valid <= 1'b0;
                if (gap_left > 0) gap_left <= gap_left - 1;
            end
            else
            begin
                in_valid <= 1'b1;
                in_data  <= meas_q.pop_front();
                if (burst_left <= 1)
                begin
                    burst_left <= $urandom_range(1, 8);
                    gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 30);
                end
                else
                    burst_left <= burst_left - 1;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Receiver: random stall pattern, redrawn each time mode_cnt wraps, plus one long hold-off
    // ------------------------------------------------------------------------
    int  stall_mode = 0;
    int  mode_cnt   = 0;
    int  hold_cnt   = 0;
    bit  hold_done  = 1'b0;

    always @(posedge clk)
    begin
        if (mode_cnt == 63) stall_mode <= $urandom_range(0, 2);
        mode_cnt <= (mode_cnt + 1) % 64;
        if (!hold_done && n_accepted == HOLD_AT)
        begin
            hold_done <= 1'b1;
            hold_cnt  <= HOLD_CYCLES;
            out_stall <= 1'b1;
        end
        else if (hold_cnt > 0)
        begin
            hold_cnt  <= hold_cnt - 1;
            out_stall <= 1'b1;
        end
        else
            case (stall_mode)
                0:       out_stall <= 1'b0;
                1:       out_stall <= ($urandom_range(0, 3) == 0);
                default: out_stall <= ($urandom_range(0, 3) != 0);
            endcase
    end

    // ------------------------------------------------------------------------
    // Monitor: predict on input beats, check on output beats
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        kse_out_t want;
        if (rst_n && in_valid && !in_stall)
        begin
            kalman_update(in_data, want);
            estimate_q.push_back(want);
            n_accepted <= n_accepted + 1;
        end
        if (rst_n && out_valid && !out_stall)
        begin
            if (estimate_q.size() == 0)
            begin
                n_mismatch <= n_mismatch + 1;
                if (n_mismatch < 10)
                    $display("unexpected result beat %h", out_data);
            end
            else
            begin
                want = estimate_q.pop_front();
                if (out_data.speed_out !== want.speed_out ||
                    out_data.accel_out !== want.accel_out ||
                    out_data.position_out !== want.position_out)
                begin
                    n_mismatch <= n_mismatch + 1;
                    if (n_mismatch < 10)
                        $display("mismatch: speed %h/%h accel %h/%h pos %h/%h (exp/got)",
                                 want.speed_out, out_data.speed_out,
                                 want.accel_out, out_data.accel_out,
                                 want.position_out, out_data.position_out);
                end
            end
        end
    end

    // Watchdog: cycles with work outstanding but no beat moving
    int idle_cnt = 0;

    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) ||
            (meas_q.size() == 0 && estimate_q.size() == 0 && !in_valid))
            idle_cnt <= 0;
        else if (idle_cnt >= IDLE_LIMIT)
        begin
            $display("FAIL kalman_speed_accel_estimator");
            $finish;
        end
        else
            idle_cnt <= idle_cnt + 1;
    end

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------
    task automatic reg_write(input logic [1:0] idx, input longint unsigned val);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 3'b000};
        pwdata  <= val;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_PROC:  noise_proc  = val & 64'h7FFF_FFFF_FFFF_FFFF;
            REG_SPEED: noise_speed = val & 64'h7FFF_FFFF_FFFF_FFFF;
            REG_ACCEL: noise_accel = val & 64'h7FFF_FFFF_FFFF_FFFF;
            default: ;
        endcase
    endtask

    task automatic drain();
        while (meas_q.size() != 0 || in_valid || estimate_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic push(input int sp, input int ac, input int unsigned dt);
        kse_in_t m;
        m.speed_meas = sp;
        m.accel_meas = ac;
        m.time_step  = dt;
        meas_q.push_back(m);
    endtask

    // Mostly a plausible trajectory with noisy measurements; some raw noise and some field extremes
    int trk_speed = 0;
    int trk_accel = 0;

    task automatic push_random(input int n);
        int unsigned sel;
        repeat (n)
        begin
            sel = $urandom_range(0, 9);
            if (sel < 7)
            begin
                trk_accel = trk_accel / 2 + $signed($urandom_range(0, 1 << 20)) - (1 << 19);
                trk_speed = trk_speed / 2 + trk_accel;
                push(trk_speed + $signed($urandom_range(0, 1 << 18)) - (1 << 17),
                     trk_accel + $signed($urandom_range(0, 1 << 16)) - (1 << 15),
                     $urandom_range(1, 1 << 26));
            end
            else if (sel < 9)
                push($urandom, $urandom, $urandom);
            else
                push(($urandom_range(0, 1) != 0) ? 32'sh7FFF_FFFF : 32'sh8000_0000,
                     ($urandom_range(0, 1) != 0) ? 32'sh7FFF_FFFF : 32'sh8000_0000,
                     ($urandom_range(0, 1) != 0) ? 32'hFFFF_FFFF : 32'd0);
        end
    endtask

    function automatic longint unsigned rand63();
        return {$urandom, $urandom} >> $urandom_range(1, 62);
    endfunction

    initial
    begin
        est_speed = 0;
        est_accel = 0;
        est_pos   = 0;
        cov       = '{65536, 0, 0, 65536};
        noise_proc  = PROC_RST;
        noise_speed = SPEED_RST;
        noise_accel = ACCEL_RST;

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        // directed beats at reset settings: field extremes
        push(0, 0, 0);
        push(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'hFFFF_FFFF);
        push(32'sh8000_0000, 32'sh8000_0000, 32'hFFFF_FFFF);
        push(32'sh7FFF_FFFF, 32'sh8000_0000, 32'd1);
        push(32'sh8000_0000, 32'sh7FFF_FFFF, 32'h8000_0000);
        push(65536, -65536, 32'd4294967);
        push(-1, 1, 32'd0);
        push(32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555);
        push(32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA);
        push_random(300);
        drain();

        // all noise zero: gain becomes one, then zero-denominator steps with dt 0
        reg_write(REG_PROC, 0);
        reg_write(REG_SPEED, 0);
        reg_write(REG_ACCEL, 0);
        push(65536, 65536, 32'd4294967);
        repeat (5) push($urandom, $urandom, 32'd0);
        push_random(150);
        drain();

        // all noise at the top of range; stray write past the last register
        reg_write(REG_PROC, 64'hFFFF_FFFF_FFFF_FFFF);
        reg_write(REG_SPEED, 64'h7FFF_FFFF_FFFF_FFFF);
        reg_write(REG_ACCEL, 64'hFFFF_FFFF_FFFF_FFFF);
        reg_write(REG_NONE, 64'd0);
        push(32'sh7FFF_FFFF, 32'sh8000_0000, 32'hFFFF_FFFF);
        push_random(150);
        drain();

        // random settings
        repeat (5)
        begin
            reg_write(REG_PROC, rand63());
            reg_write(REG_SPEED, rand63());
            reg_write(REG_ACCEL, rand63());
            push_random(220);
            drain();
        end

        // back to defaults
        reg_write(REG_PROC, PROC_RST);
        reg_write(REG_SPEED, SPEED_RST);
        reg_write(REG_ACCEL, ACCEL_RST);
        push_random(40);
        drain();

        if (n_mismatch == 0 && estimate_q.size() == 0)
            $display("PASS kalman_speed_accel_estimator");
        else
            $display("FAIL kalman_speed_accel_estimator");
        $finish;
    end

endmodule

// ----- files.f -----
rtl/kse_pkg.sv
rtl/kse_arith.sv
rtl/kse_seq.sv
rtl/kalman_speed_accel_estimator.sv
test/testbench.sv
